// ===== sv/signed_decimal_formatter_unit_defines.svh =====
// Assertion macros shared by the signed decimal formatter RTL.
`ifndef SIGNED_DECIMAL_FORMATTER_UNIT_DEFINES_SVH
`define SIGNED_DECIMAL_FORMATTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SDF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("signed decimal formatter: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define SDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("signed decimal formatter: next-cycle check failed");
`else
`define SDF_ASSERT_SAME(label, clk, rst, ante, cons)
`define SDF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/sdf_pkg.sv =====
// Shared types and constants of the signed decimal formatter.
package sdf_pkg;

   localparam int MAX_FIELD     = 48;
   localparam int VALUE_W       = 64;
   localparam int NUM_DIGITS    = 20;
   localparam int BCD_W         = NUM_DIGITS * 4;
   localparam int DIG_IDX_W     = $clog2(NUM_DIGITS);
   localparam int SIG_W         = $clog2(NUM_DIGITS + 1);
   localparam int CNT_W         = $clog2(MAX_FIELD + 2);
   localparam int BITS_PER_STEP = 4;
   localparam int STEP_W        = $clog2(VALUE_W / BITS_PER_STEP + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_ADDR_W-1:0] CSR_FIELD_WIDTH     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_DIGITS      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRECISION_GIVEN = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FORMAT_FLAGS    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LENGTH_MODE     = 3'd4;

   localparam logic [1:0] LEN_SHORT = 2'd0;
   localparam logic [1:0] LEN_INT   = 2'd1;
   localparam logic [1:0] LEN_LONG  = 2'd2;

   localparam int FLAG_LEFT  = 0;
   localparam int FLAG_PLUS  = 1;
   localparam int FLAG_SPACE = 2;
   localparam int FLAG_ZERO  = 3;

   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [6:0] CHAR_PLUS  = 7'h2B;
   localparam logic [6:0] CHAR_SPACE = 7'h20;

   typedef struct packed {
      logic load;
      logic step;
      logic measure;
      logic layout;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic text_empty;
      logic last_char;
   } status_type;

endpackage

// ===== sv/sdf_datapath.sv =====
// Datapath: config registers, binary-to-BCD converter, layout counters, output register.
module sdf_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [sdf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [sdf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [sdf_pkg::VALUE_W-1:0]      value,
   input  sdf_pkg::cmd_type                 cmd,
   output sdf_pkg::status_type              status,
   output logic [6:0]                       rsp_char,
   output logic                             rsp_last
);

   logic [5:0] field_width_ff;
   logic [5:0] min_digits_ff;
   logic       precision_given_ff;
   logic [3:0] format_flags_ff;
   logic [1:0] length_mode_ff;

   logic [sdf_pkg::VALUE_W-1:0]   bin_ff,  bin_in;
   logic [sdf_pkg::BCD_W-1:0]     bcd_ff,  bcd_in;
   logic [sdf_pkg::STEP_W-1:0]    steps_ff;
   logic                          neg_ff;
   logic                          mag_zero_ff;
   logic [sdf_pkg::SIG_W-1:0]     sig_ff,  sig_in;
   logic [sdf_pkg::CNT_W-1:0]     nd_ff,   nd_in;
   logic [sdf_pkg::CNT_W-1:0]     lead_ff;
   logic                          sign_ff;
   logic [6:0]                    sign_char_ff;
   logic [sdf_pkg::CNT_W-1:0]     zfill_ff;
   logic [sdf_pkg::CNT_W-1:0]     pos_ff;
   logic [sdf_pkg::CNT_W-1:0]     rem_ff;
   logic [6:0]                    rsp_char_ff, rsp_char_in;
   logic                          rsp_last_ff;

   logic [sdf_pkg::VALUE_W-1:0]   narrowed;
   logic                          neg;
   logic [sdf_pkg::VALUE_W-1:0]   mag;
   logic [sdf_pkg::VALUE_W-1:0]   mag_aligned;
   logic [sdf_pkg::STEP_W-1:0]    steps_load;

   logic [sdf_pkg::CNT_W-1:0]     width_sat;
   logic [sdf_pkg::CNT_W-1:0]     prec_sat;
   logic                          has_sign;
   logic [6:0]                    sign_char;
   logic [sdf_pkg::CNT_W-1:0]     body;
   logic [sdf_pkg::CNT_W-1:0]     pad;
   logic                          zero_fill_mode;
   logic [sdf_pkg::CNT_W-1:0]     dig_idx;
   logic [3:0]                    dig_val;

   // Narrow by length mode and take the unsigned magnitude
   always_comb begin
      case (length_mode_ff)
         sdf_pkg::LEN_SHORT: begin
            narrowed    = {{(sdf_pkg::VALUE_W-16){value[15]}}, value[15:0]};
         end
         sdf_pkg::LEN_LONG: begin
            narrowed    = value;
         end
         default: begin
            narrowed    = {{(sdf_pkg::VALUE_W-32){value[31]}}, value[31:0]};
         end
      endcase
      neg = narrowed[sdf_pkg::VALUE_W-1];
      mag = neg ? (~narrowed + sdf_pkg::VALUE_W'(1)) : narrowed;
      case (length_mode_ff)
         sdf_pkg::LEN_SHORT: begin
            mag_aligned = mag << (sdf_pkg::VALUE_W - 16);
            steps_load  = sdf_pkg::STEP_W'(16 / sdf_pkg::BITS_PER_STEP);
         end
         sdf_pkg::LEN_LONG: begin
            mag_aligned = mag;
            steps_load  = sdf_pkg::STEP_W'(sdf_pkg::VALUE_W / sdf_pkg::BITS_PER_STEP);
         end
         default: begin
            mag_aligned = mag << (sdf_pkg::VALUE_W - 32);
            steps_load  = sdf_pkg::STEP_W'(32 / sdf_pkg::BITS_PER_STEP);
         end
      endcase
   end

   // Double dabble, several bits per step
   always_comb begin
      bcd_in = bcd_ff;
      bin_in = bin_ff;
      for (int s = 0; s < sdf_pkg::BITS_PER_STEP; s++) begin
         for (int d = 0; d < sdf_pkg::NUM_DIGITS; d++) begin
            if (bcd_in[d*4 +: 4] >= 4'd5) begin
               bcd_in[d*4 +: 4] = bcd_in[d*4 +: 4] + 4'd3;
            end
         end
         bcd_in = {bcd_in[sdf_pkg::BCD_W-2:0], bin_in[sdf_pkg::VALUE_W-1]};
         bin_in = {bin_in[sdf_pkg::VALUE_W-2:0], 1'b0};
      end
   end

   // Significant digit count and total digit count
   always_comb begin
      width_sat = (field_width_ff > 6'(sdf_pkg::MAX_FIELD)) ?
                  sdf_pkg::CNT_W'(sdf_pkg::MAX_FIELD) : sdf_pkg::CNT_W'(field_width_ff);
      prec_sat  = (min_digits_ff > 6'(sdf_pkg::MAX_FIELD)) ?
                  sdf_pkg::CNT_W'(sdf_pkg::MAX_FIELD) : sdf_pkg::CNT_W'(min_digits_ff);
      sig_in = sdf_pkg::SIG_W'(1);
      for (int d = 1; d < sdf_pkg::NUM_DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            sig_in = sdf_pkg::SIG_W'(d + 1);
         end
      end
      if (mag_zero_ff && precision_given_ff && (prec_sat == '0)) begin
         nd_in = '0;
      end else if (prec_sat > sdf_pkg::CNT_W'(sig_in)) begin
         nd_in = prec_sat;
      end else begin
         nd_in = sdf_pkg::CNT_W'(sig_in);
      end
   end

   // Sign and padding
   always_comb begin
      has_sign = neg_ff || format_flags_ff[sdf_pkg::FLAG_PLUS] ||
                 format_flags_ff[sdf_pkg::FLAG_SPACE];
      if (neg_ff) begin
         sign_char = sdf_pkg::CHAR_MINUS;
      end else if (format_flags_ff[sdf_pkg::FLAG_PLUS]) begin
         sign_char = sdf_pkg::CHAR_PLUS;
      end else begin
         sign_char = sdf_pkg::CHAR_SPACE;
      end
      body = nd_ff + sdf_pkg::CNT_W'(has_sign);
      pad  = (width_sat > body) ? (width_sat - body) : '0;
      zero_fill_mode = format_flags_ff[sdf_pkg::FLAG_ZERO] && !precision_given_ff;
   end

   // Next character: leading spaces, sign, zero fill, digits, trailing spaces
   always_comb begin
      dig_idx = pos_ff - sdf_pkg::CNT_W'(1);
      dig_val = bcd_ff[{dig_idx[sdf_pkg::DIG_IDX_W-1:0], 2'b00} +: 4];
      if (lead_ff != '0) begin
         rsp_char_in = sdf_pkg::CHAR_SPACE;
      end else if (sign_ff) begin
         rsp_char_in = sign_char_ff;
      end else if (zfill_ff != '0) begin
         rsp_char_in = sdf_pkg::CHAR_ZERO;
      end else if (pos_ff != '0) begin
         if (dig_idx < sdf_pkg::CNT_W'(sig_ff)) begin
            rsp_char_in = sdf_pkg::CHAR_ZERO + 7'(dig_val);
         end else begin
            rsp_char_in = sdf_pkg::CHAR_ZERO;
         end
      end else begin
         rsp_char_in = sdf_pkg::CHAR_SPACE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff     <= '0;
         min_digits_ff      <= '0;
         precision_given_ff <= 1'b0;
         format_flags_ff    <= '0;
         length_mode_ff     <= sdf_pkg::LEN_INT;
      end else if (csr_we) begin
         case (csr_addr)
            sdf_pkg::CSR_FIELD_WIDTH:     field_width_ff     <= csr_wdata[5:0];
            sdf_pkg::CSR_MIN_DIGITS:      min_digits_ff      <= csr_wdata[5:0];
            sdf_pkg::CSR_PRECISION_GIVEN: precision_given_ff <= csr_wdata[0];
            sdf_pkg::CSR_FORMAT_FLAGS:    format_flags_ff    <= csr_wdata[3:0];
            sdf_pkg::CSR_LENGTH_MODE:     length_mode_ff     <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bin_ff      <= mag_aligned;
         bcd_ff      <= '0;
         steps_ff    <= steps_load;
         neg_ff      <= neg;
         mag_zero_ff <= (mag == '0);
      end else if (cmd.step) begin
         bin_ff   <= bin_in;
         bcd_ff   <= bcd_in;
         steps_ff <= steps_ff - sdf_pkg::STEP_W'(1);
      end
      if (cmd.measure) begin
         sig_ff <= sig_in;
         nd_ff  <= nd_in;
      end
      if (cmd.layout) begin
         sign_ff      <= has_sign;
         sign_char_ff <= sign_char;
         pos_ff       <= nd_ff;
         rem_ff       <= pad + body;
         if (format_flags_ff[sdf_pkg::FLAG_LEFT]) begin
            lead_ff  <= '0;
            zfill_ff <= '0;
         end else if (zero_fill_mode) begin
            lead_ff  <= '0;
            zfill_ff <= pad;
         end else begin
            lead_ff  <= pad;
            zfill_ff <= '0;
         end
      end else if (cmd.emit) begin
         rsp_char_ff <= rsp_char_in;
         rsp_last_ff <= (rem_ff == sdf_pkg::CNT_W'(1));
         rem_ff      <= rem_ff - sdf_pkg::CNT_W'(1);
         if (lead_ff != '0) begin
            lead_ff <= lead_ff - sdf_pkg::CNT_W'(1);
         end else if (sign_ff) begin
            sign_ff <= 1'b0;
         end else if (zfill_ff != '0) begin
            zfill_ff <= zfill_ff - sdf_pkg::CNT_W'(1);
         end else if (pos_ff != '0) begin
            pos_ff <= pos_ff - sdf_pkg::CNT_W'(1);
         end
      end
   end

   assign status.conv_done  = (steps_ff == sdf_pkg::STEP_W'(1));
   assign status.text_empty = (pad == '0) && (body == '0);
   assign status.last_char  = (rem_ff == sdf_pkg::CNT_W'(1));
   assign rsp_char          = rsp_char_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== sv/sdf_ctrl.sv =====
// Controller: sequences load, conversion, layout and character emission.
module sdf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  sdf_pkg::status_type status,
   output sdf_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_MEASURE,
      ST_LAYOUT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      req_tready  = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.step = 1'b1;
            if (status.conv_done) begin
               state_in = ST_MEASURE;
            end
         end
         ST_MEASURE: begin
            cmd.measure = 1'b1;
            state_in    = ST_LAYOUT;
         end
         ST_LAYOUT: begin
            cmd.layout = 1'b1;
            state_in   = status.text_empty ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            // load the output register once the previous character has left
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               if (status.last_char) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.emit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

// ===== sv/signed_decimal_formatter_unit.sv =====
// Top level of the signed decimal formatter.
// Formats one signed integer per request transaction as printf "%d" text and
// returns it one ASCII character per response transaction, tlast on the final
// character. The value is narrowed to 16, 32 or 64 bits by the length mode;
// width, precision and flags come from the csr registers, which the user must
// write only while the block is idle; the block itself does not enforce this.
// The binary-to-BCD converter takes 4 bits per cycle; a value is loaded,
// converted, measured and laid out before its characters leave at one per
// cycle while the sink is ready. A value whose text is empty returns no
// response. A new request is taken once the last character of the previous
// one sits in the output register.
`include "signed_decimal_formatter_unit_defines.svh"
module signed_decimal_formatter_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [sdf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [sdf_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [63:0]                    req_tdata,   // [63:0] value
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [6:0] character, [7] zero
   output logic                           rsp_tlast    // last
);

   sdf_pkg::cmd_type    cmd;
   sdf_pkg::status_type status;
   logic [6:0]          rsp_char;

   sdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sdf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .value     (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_char  (rsp_char),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_char};

   `SDF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `SDF_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.emit, !rsp_tvalid || rsp_tready)
   `SDF_ASSERT_NEXT(a_emit_shows_valid, clock, reset, cmd.emit, rsp_tvalid)

endmodule
